/* hdl/dqz_pkg.sv */
// Shared constants, tables and types for the JPEG quantizer / zigzag core.
// Used by dqz_quant and dct_quantize_zigzag_core; depends on nothing else.
package dqz_pkg;

	localparam int BLOCK_LEN = 64;
	localparam int POS_W     = 6;
	localparam int COEF_W    = 14;
	localparam int CHAN_W    = 2;
	localparam int VAL_W     = 8;
	localparam int QTAB_W    = 8;

	// Reciprocal scaling: floor(n * R >> RCP_SHIFT) equals floor(n / (8Q)) exactly
	// for every n below 2^14 and every divisor 8Q below 2^10.
	localparam int RCP_SHIFT = 24;
	localparam int RCP_W     = 18;
	localparam int PROD_W    = 32;

	localparam logic [CHAN_W-1:0] CHAN_LUMA = CHAN_W'(0);

	localparam logic [QTAB_W-1:0] LUMA_Q [BLOCK_LEN] = '{
		8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
		8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
		8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
		8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
		8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
		8'd24, 8'd36, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
		8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
		8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
	};

	localparam logic [QTAB_W-1:0] CHROMA_Q [BLOCK_LEN] = '{
		8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
	};

	// Raster address read at each zigzag output position.
	localparam logic [POS_W-1:0] ZIGZAG [BLOCK_LEN] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	// Store write request from the quantizer pipeline.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [POS_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} wr_t;

endpackage

/* hdl/dct_quantize_zigzag_core.sv */
// JPEG quantizer with zigzag readout for one 8x8 block, built around a 64x8 RAM.
// Fill: one coefficient per cycle; each result is written after the quantizer registers.
// After the last write, the first output word passes the RAM read register and the output
// register, then one word per cycle follows while the consumer takes it. Coefficients
// are held off until the last read issues. Reset clears the control state only; the RAM
// is not cleared, since every entry is written before it is read.
module dct_quantize_zigzag_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              coef_valid,
	output logic                              coef_ready,
	input  logic signed [dqz_pkg::COEF_W-1:0] coefficient,
	input  logic [dqz_pkg::CHAN_W-1:0]        channel,
	output logic                              value_valid,
	input  logic                              value_ready,
	output logic signed [dqz_pkg::VAL_W-1:0]  quantized_value,
	output logic                              last_of_block
);
	import dqz_pkg::*;

	localparam logic [1:0] ST_FILL = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]       state_q;
	logic [POS_W-1:0] count_q;
	logic [POS_W-1:0] rd_idx_q;
	logic             rd_pend_q;
	logic             rd_last_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic [VAL_W-1:0] out_val_q;

	logic             coef_take;
	logic             rd_issue;
	logic             out_load;
	logic             rd_final;
	logic [VAL_W-1:0] rd_data;
	wr_t              wr;

	assign coef_ready = (state_q == ST_FILL);
	assign coef_take  = coef_valid && coef_ready;

	dqz_quant u_quant (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (coef_take),
		.coefficient (coefficient),
		.channel     (channel),
		.pos         (count_q),
		.wr          (wr)
	);

	dqz_ram #(
		.WIDTH (VAL_W),
		.DEPTH (BLOCK_LEN)
	) u_store (
		.clk     (clk),
		.wr_en   (wr.valid),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (rd_issue),
		.rd_addr (ZIGZAG[rd_idx_q]),
		.rd_data (rd_data)
	);

	// The RAM read register holds its word until the output register can take it,
	// so a new read is issued only when that word moves on in the same cycle.
	assign out_load = rd_pend_q && (!out_valid_q || value_ready);
	assign rd_issue = (state_q == ST_READ) && (!rd_pend_q || out_load);
	assign rd_final = (rd_idx_q == POS_W'(BLOCK_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_pend_q   <= 1'b0;
			rd_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (coef_take) begin
						count_q <= count_q + POS_W'(1);
						if (count_q == POS_W'(BLOCK_LEN - 1)) begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (wr.valid && wr.last) begin
						state_q  <= ST_READ;
						rd_idx_q <= '0;
					end
				end
				ST_READ: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + POS_W'(1);
						if (rd_final) begin
							state_q <= ST_FILL;
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase

			rd_pend_q <= rd_issue || (rd_pend_q && !out_load);
			if (rd_issue) begin
				rd_last_q <= rd_final;
			end
			out_valid_q <= out_load || (out_valid_q && !value_ready);
			if (out_load) begin
				out_last_q <= rd_last_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q <= rd_data;
		end
	end

	assign value_valid     = out_valid_q;
	assign quantized_value = out_val_q;
	assign last_of_block   = out_last_q;

endmodule

/* hdl/dqz_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; depends on nothing.
module dqz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/dqz_quant.sv */
// Two-stage quantizer: table lookup and rounding offset, then reciprocal multiply.
// Produces a store write request; depends on dqz_pkg.
module dqz_quant (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [dqz_pkg::COEF_W-1:0] coefficient,
	input  logic [dqz_pkg::CHAN_W-1:0]     channel,
	input  logic [dqz_pkg::POS_W-1:0]      pos,
	output dqz_pkg::wr_t                   wr
);
	import dqz_pkg::*;

	logic [RCP_W-1:0]  luma_rcp   [BLOCK_LEN];
	logic [RCP_W-1:0]  chroma_rcp [BLOCK_LEN];
	logic              is_luma;
	logic              neg;
	logic [COEF_W-1:0] mag;
	logic [QTAB_W-1:0] qsel;
	logic [RCP_W-1:0]  rsel;
	logic [COEF_W-1:0] num;
	logic [VAL_W-1:0]  res;
	logic [VAL_W-1:0]  sat_val;

	logic              valid_s1, valid_s2;
	logic              last_s1, last_s2;
	logic              neg_s1, neg_s2;
	logic [POS_W-1:0]  addr_s1, addr_s2;
	logic [COEF_W-1:0] num_s1;
	logic [RCP_W-1:0]  rcp_s1;
	logic [PROD_W-1:0] prod_s2;

	// Reciprocals of eight times each table entry, rounded up, settled at elaboration.
	for (genvar g = 0; g < BLOCK_LEN; g++) begin : g_rcp
		localparam int unsigned LUMA_R =
			((1 << RCP_SHIFT) + 8 * LUMA_Q[g] - 1) / (8 * LUMA_Q[g]);
		localparam int unsigned CHROMA_R =
			((1 << RCP_SHIFT) + 8 * CHROMA_Q[g] - 1) / (8 * CHROMA_Q[g]);
		assign luma_rcp[g]   = RCP_W'(LUMA_R);
		assign chroma_rcp[g] = RCP_W'(CHROMA_R);
	end

	always_comb begin
		is_luma = (channel == CHAN_LUMA);
		neg     = coefficient[COEF_W-1];
		mag     = neg ? COEF_W'(-coefficient) : COEF_W'(coefficient);
		qsel    = is_luma ? LUMA_Q[pos] : CHROMA_Q[pos];
		rsel    = is_luma ? luma_rcp[pos] : chroma_rcp[pos];
		// Adding 4Q before dividing by 8Q rounds the magnitude half away from zero.
		num     = mag + COEF_W'({qsel, 2'b00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (pos == POS_W'(BLOCK_LEN - 1));
		neg_s1  <= neg;
		addr_s1 <= pos;
		num_s1  <= num;
		rcp_s1  <= rsel;
		last_s2 <= last_s1;
		neg_s2  <= neg_s1;
		addr_s2 <= addr_s1;
		prod_s2 <= PROD_W'(num_s1) * PROD_W'(rcp_s1);
	end

	always_comb begin
		res = prod_s2[RCP_SHIFT +: VAL_W];
		if (neg_s2) begin
			sat_val = (res > VAL_W'(128)) ? VAL_W'(128) : res;
			sat_val = VAL_W'(-sat_val);
		end else begin
			sat_val = (res > VAL_W'(127)) ? VAL_W'(127) : res;
		end
		wr.valid = valid_s2;
		wr.last  = last_s2;
		wr.addr  = addr_s2;
		wr.data  = sat_val;
	end

endmodule
